// ----- sv/assembler_token_splitter_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the assembler token splitter checker
// ---------------------------------------------------------------------------
`ifndef ASSEMBLER_TOKEN_SPLITTER_DEFINES_SVH
`define ASSEMBLER_TOKEN_SPLITTER_DEFINES_SVH

// Property holds in the same cycle as its antecedent.
`define ATS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Property holds in the cycle after its antecedent.
`define ATS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/ats_pkg.sv -----
// ---------------------------------------------------------------------------
// ats_pkg
// Types and character constants shared by the assembler token splitter.
// ---------------------------------------------------------------------------
`default_nettype none

package ats_pkg;

   // Token length and nesting limits
   localparam logic [7:0] MAX_TOKEN = 8'd255;
   localparam logic [7:0] MAX_NEST  = 8'd255;

   // Characters with a meaning of their own
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_LPAREN    = 8'h28;
   localparam logic [7:0] CHAR_RPAREN    = 8'h29;
   localparam logic [7:0] CHAR_LBRACKET  = 8'h5B;
   localparam logic [7:0] CHAR_RBRACKET  = 8'h5D;
   localparam logic [7:0] CHAR_SLASH     = 8'h2F;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_VTAB      = 8'h0B;
   localparam logic [7:0] CHAR_FORMFEED  = 8'h0C;
   localparam logic [7:0] CHAR_RETURN    = 8'h0D;

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_TOKEN   = 2'd1,
      MODE_BLOCK   = 2'd2,
      MODE_COMMENT = 2'd3
   } mode_type;

   // Result flags as they sit in rsp_tuser, lowest bit last in this list
   typedef struct packed {
      logic end_after;
      logic char_valid;
      logic end_before;
      logic held_slash;
   } rsp_flags_type;

endpackage

`default_nettype wire

// ----- sv/assembler_token_splitter.sv -----
// ---------------------------------------------------------------------------
// assembler_token_splitter
// Byte-at-a-time tokenizer for assembler source text.
// ---------------------------------------------------------------------------
// Input channel req_*: one source byte per beat in req_tdata; a beat with
// req_tuser high is a flush marker whose byte is ignored: it releases a held
// slash, closes any open token and returns the tokenizer to its start state.
// Result channel rsp_*: exactly one beat per input beat, in order. rsp_tdata
// carries the kept character, rsp_tuser the flags that say where tokens end.
// There is one input register and one result register with the byte
// decision between them. Throughput is one byte per cycle while rsp_tready
// stays high; the input register takes a new beat in the same cycle that
// the result register hands its beat on.
// When rsp_tready is low the result register holds its beat, the input
// register fills behind it, and req_tready then drops until the result is
// taken; no beat is lost or repeated.
// Reset clears both valid bits and all tokenizer state (no token open, no
// held slash, no pending drop).
// ---------------------------------------------------------------------------
`default_nettype none

module assembler_token_splitter
   import ats_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] byte_req
   input  wire logic       req_tuser,   // [0] end_of_stream
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] char_out
   output logic [3:0]      rsp_tuser    // [0] held_slash, [1] end_before,
                                        // [2] char_valid, [3] end_after
);

   // Input register
   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_eos_ff;

   // Result register
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic [7:0]    rsp_char_ff;
   logic [7:0]    rsp_char_in;
   rsp_flags_type rsp_flags_ff;
   rsp_flags_type rsp_flags_in;

   // Tokenizer state
   mode_type   mode_ff;
   mode_type   mode_in;
   logic [7:0] nest_ff;
   logic [7:0] nest_in;
   logic       is_string_ff;
   logic       is_string_in;
   logic [7:0] token_len_ff;
   logic [7:0] token_len_in;
   logic       drop_next_ff;
   logic       drop_next_in;
   logic       slash_held_ff;
   logic       slash_held_in;

   logic advance;
   logic accept;
   logic is_blank;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   assign is_blank = (in_byte_ff == CHAR_SPACE)    || (in_byte_ff == CHAR_TAB)
                  || (in_byte_ff == CHAR_NEWLINE)  || (in_byte_ff == CHAR_VTAB)
                  || (in_byte_ff == CHAR_FORMFEED) || (in_byte_ff == CHAR_RETURN);

   // Byte decision: next tokenizer state and the result character and flags
   always_comb begin
      logic       do_keep;
      logic       force_end;
      logic [7:0] len_kept;
      logic [7:0] len_slash;
      logic       last_paren;

      mode_in       = mode_ff;
      nest_in       = nest_ff;
      is_string_in  = is_string_ff;
      token_len_in  = token_len_ff;
      drop_next_in  = drop_next_ff;
      slash_held_in = slash_held_ff;
      rsp_flags_in  = '0;
      rsp_char_in   = '0;
      do_keep       = 1'b0;
      force_end     = 1'b0;
      len_kept      = '0;
      len_slash     = '0;
      last_paren    = 1'b0;

      if (in_eos_ff) begin
         rsp_flags_in.held_slash = slash_held_ff;
         rsp_flags_in.end_before = (mode_ff == MODE_TOKEN) || (mode_ff == MODE_BLOCK)
                                 || slash_held_ff;
         mode_in       = MODE_IDLE;
         nest_in       = '0;
         is_string_in  = 1'b0;
         token_len_in  = '0;
         drop_next_in  = 1'b0;
         slash_held_in = 1'b0;
      end else if (drop_next_ff) begin
         drop_next_in = 1'b0;
      end else if (mode_ff == MODE_COMMENT) begin
         if (in_byte_ff == CHAR_NEWLINE) begin
            mode_in = MODE_IDLE;
         end
      end else if (mode_ff == MODE_BLOCK) begin
         if (is_string_ff) begin
            if (in_byte_ff == CHAR_BACKSLASH) begin
               drop_next_in = 1'b1;
            end else begin
               do_keep   = 1'b1;
               force_end = (in_byte_ff == CHAR_QUOTE);
            end
         end else begin
            do_keep = 1'b1;
            if (in_byte_ff == CHAR_LPAREN) begin
               if (nest_ff < MAX_NEST) begin
                  nest_in = nest_ff + 8'd1;
               end
            end else if (in_byte_ff == CHAR_RPAREN) begin
               last_paren = (nest_ff <= 8'd1);
               if (nest_ff != 8'd0) begin
                  nest_in = nest_ff - 8'd1;
               end
               force_end = last_paren;
            end
         end
      end else if (in_byte_ff == CHAR_SLASH && slash_held_ff) begin
         // second slash: close the open token and enter the comment
         slash_held_in           = 1'b0;
         rsp_flags_in.end_before = (mode_ff == MODE_TOKEN);
         nest_in                 = '0;
         is_string_in            = 1'b0;
         token_len_in            = '0;
         mode_in                 = MODE_COMMENT;
      end else if (in_byte_ff == CHAR_SLASH) begin
         slash_held_in = 1'b1;
      end else begin
         // release a held slash into the token first
         if (slash_held_ff) begin
            slash_held_in           = 1'b0;
            rsp_flags_in.held_slash = 1'b1;
            mode_in                 = MODE_TOKEN;
            len_slash               = token_len_ff + 8'd1;
            token_len_in            = len_slash;
            if (len_slash >= MAX_TOKEN) begin
               rsp_flags_in.end_before = 1'b1;
               mode_in                 = MODE_IDLE;
               nest_in                 = '0;
               is_string_in            = 1'b0;
               token_len_in            = '0;
            end
         end
         if (is_blank) begin
            if (mode_in == MODE_TOKEN) begin
               rsp_flags_in.end_before = 1'b1;
            end
            mode_in      = MODE_IDLE;
            nest_in      = '0;
            is_string_in = 1'b0;
            token_len_in = '0;
         end else if (in_byte_ff == CHAR_BACKSLASH) begin
            drop_next_in = 1'b1;
         end else if (in_byte_ff == CHAR_QUOTE) begin
            mode_in      = MODE_BLOCK;
            is_string_in = 1'b1;
            nest_in      = '0;
            do_keep      = 1'b1;
         end else if (in_byte_ff == CHAR_LPAREN) begin
            mode_in      = MODE_BLOCK;
            is_string_in = 1'b0;
            nest_in      = 8'd1;
            do_keep      = 1'b1;
         end else if (in_byte_ff == CHAR_LBRACKET || in_byte_ff == CHAR_RBRACKET) begin
            // one-character token: end what is open, keep, end again
            if (mode_in == MODE_TOKEN) begin
               rsp_flags_in.end_before = 1'b1;
            end
            mode_in      = MODE_IDLE;
            nest_in      = '0;
            is_string_in = 1'b0;
            token_len_in = '0;
            do_keep      = 1'b1;
            force_end    = 1'b1;
         end else begin
            mode_in = MODE_TOKEN;
            do_keep = 1'b1;
         end
      end

      // Append the byte; the length limit or a closing byte ends the token
      if (do_keep) begin
         rsp_char_in             = in_byte_ff;
         rsp_flags_in.char_valid = 1'b1;
         len_kept                = token_len_in + 8'd1;
         if (force_end || len_kept >= MAX_TOKEN) begin
            rsp_flags_in.end_after = 1'b1;
            mode_in                = MODE_IDLE;
            nest_in                = '0;
            is_string_in           = 1'b0;
            token_len_in           = '0;
         end else begin
            token_len_in = len_kept;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         mode_ff       <= MODE_IDLE;
         nest_ff       <= '0;
         is_string_ff  <= 1'b0;
         token_len_ff  <= '0;
         drop_next_ff  <= 1'b0;
         slash_held_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            mode_ff       <= mode_in;
            nest_ff       <= nest_in;
            is_string_ff  <= is_string_in;
            token_len_ff  <= token_len_in;
            drop_next_ff  <= drop_next_in;
            slash_held_ff <= slash_held_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_tdata;
         in_eos_ff  <= req_tuser;
      end
      if (advance) begin
         rsp_char_ff  <= rsp_char_in;
         rsp_flags_ff <= rsp_flags_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tuser  = rsp_flags_ff;

endmodule

`default_nettype wire

// ----- sv/ats_checker.sv -----
// ---------------------------------------------------------------------------
// ats_checker
// Port-level checks for the assembler token splitter.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assembler_token_splitter_defines.svh"

module ats_checker
   import ats_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tready,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic [3:0] rsp_tuser
);

   rsp_flags_type flags;

   assign flags = rsp_tuser;

   // stalled result beat holds
   `ATS_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result beat changed")

   // a token can end after a byte only if that byte was kept
   `ATS_ASSERT_NOW(a_end_after_kept, rsp_tvalid && flags.end_after, flags.char_valid, "end_after without a kept byte")

   // a dropped byte shows as zero
   `ATS_ASSERT_NOW(a_drop_zero, rsp_tvalid && !flags.char_valid, rsp_tdata == 8'h00, "dropped byte not zero")

   // a released slash is never followed by a kept slash in the same beat
   `ATS_ASSERT_NOW(a_slash_release, rsp_tvalid && flags.held_slash && flags.char_valid, rsp_tdata != CHAR_SLASH, "slash kept after slash release")

   // input backpressure only while a result beat waits on the receiver
   `ATS_ASSERT_NOW(a_ready_stall, !req_tready, rsp_tvalid && !rsp_tready, "input stalled without a waiting result")

endmodule

bind assembler_token_splitter ats_checker u_ats_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
